FILE: hdl/fsba_pkg.sv
package fsba_pkg;

  localparam int OPCODE_W  = 2;
  localparam int FILE_ID_W = 16;
  localparam int STATUS_W  = 3;
  localparam int SLOT_IDX_W = 6;
  localparam int BLOCK_NUM_W = 9;
  localparam int LIMIT_W   = 10;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 10'd512;

  // block map is stored as rows of ROW_W flags
  localparam int ROW_W  = 32;
  localparam int ROW_BW = 5;
  localparam logic [ROW_W-1:0] ROW0_RESET = 32'h0000_0003;

  typedef enum logic [OPCODE_W-1:0] {
    OP_CREATE = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_EXISTS    = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_NO_BLOCK  = 3'd3,
    ST_NOT_FOUND = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_BSCAN,
    S_COMMIT,
    S_DREAD,
    S_DMOD,
    S_RESP
  } state_t;

endpackage

FILE: hdl/fsba_if.sv
interface fsba_req_if import fsba_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [OPCODE_W-1:0]  opcode;
  logic [FILE_ID_W-1:0] file_id;

  modport source (output valid, output opcode, output file_id, input ready);
  modport sink   (input valid, input opcode, input file_id, output ready);
endinterface

interface fsba_rsp_if import fsba_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_W-1:0]    status;
  logic [SLOT_IDX_W-1:0]  slot_index;
  logic [BLOCK_NUM_W-1:0] blk_num;

  modport source (output valid, output status, output slot_index, output blk_num,
                  input ready);
  modport sink   (input valid, input status, input slot_index, input blk_num,
                  output ready);
endinterface

interface fsba_cfg_if import fsba_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LIMIT_W-1:0] data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hdl/file_slot_and_block_allocator.sv
// One item at a time. Create, delete and lookup scan the slot table; an unused opcode goes
// straight to the result. Create, if the ID is new and a slot is free, adds a scan of the block map
// in rows of 32, then a commit that writes the slot and the map row. Delete of a found file
// reads and then rewrites its map row. The next item can be taken in the cycle after the
// result is loaded; a result waiting in the out reg stalls the load.
// Reset: all slots free, block_limit 512, blocks 0 and 1 used, no clearing pass.
module file_slot_and_block_allocator import fsba_pkg::*; #(
  parameter int SLOTS   = 64,
  parameter int BLOCKS  = 512,
  parameter int ID_BITS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  fsba_req_if.sink   in_ch,
  fsba_rsp_if.source out_ch,
  fsba_cfg_if.sink   cfg_ch
);

  localparam int SB   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int BW   = $clog2(BLOCKS);
  localparam int ROWS = (BLOCKS + ROW_W - 1) / ROW_W;
  localparam int RB   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LW   = ($clog2(BLOCKS + 1) > LIMIT_W) ? $clog2(BLOCKS + 1) : LIMIT_W;
  localparam int CW   = (LW > RB + ROW_BW) ? LW : RB + ROW_BW;
  localparam int EW   = ID_BITS + BW;
  localparam logic [SB-1:0] SLOT_LAST = SB'(SLOTS - 1);
  localparam logic [RB-1:0] ROW_LAST  = RB'(ROWS - 1);

  // memories
  logic [EW-1:0]    slot_mem [SLOTS];
  logic [ROW_W-1:0] blk_mem  [ROWS];
  logic [EW-1:0]    slot_rd_r;
  logic [ROW_W-1:0] blk_rd_r;

  // control state
  state_t             state_r, state_nxt;
  logic [LIMIT_W-1:0] limit_r;
  logic [SLOTS-1:0]   slot_vld_r;
  logic [ROWS-1:0]    row_vld_r;
  logic               iss_on_r, chk_on_r, bis_on_r, bchk_on_r;
  logic               out_vld_r;

  // datapath
  op_t                op_r;
  logic [ID_BITS-1:0] id_r;
  logic [SB-1:0]      iss_r, chk_idx_r;
  logic [RB-1:0]      bis_r, bchk_row_r;
  logic               match_r, free_r, bfound_r;
  logic [SB-1:0]      match_slot_r, free_slot_r;
  logic [BW-1:0]      match_blk_r, bfound_blk_r;
  logic [RB-1:0]      bfound_row_r;
  logic [ROW_BW-1:0]  bfound_bit_r;
  logic [ROW_W-1:0]   bfound_word_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [SLOT_IDX_W-1:0]  out_slot_r;
  logic [BLOCK_NUM_W-1:0] out_blk_r;

  // combinational
  logic               accept;
  logic [LW-1:0]      lim_ext, lim;
  logic [ID_BITS-1:0] slot_rd_id;
  logic [BW-1:0]      slot_rd_blk;
  logic               hit_now, free_now, scan_end, match_any, free_any;
  logic [RB-1:0]      del_row, chk_row;
  logic [ROW_BW-1:0]  del_bit;
  logic [ROW_W-1:0]   row_eff, avail;
  logic [ROW_BW-1:0]  pick_bit;
  logic               pick_any, bfree_now, bscan_end;
  logic               slot_we, blk_we, load_out;
  logic [RB-1:0]      blk_waddr, blk_raddr;
  logic [ROW_W-1:0]   blk_wdata;
  status_t            res_status;
  logic [SB-1:0]      res_slot;
  logic [BW-1:0]      res_blk;

  function automatic logic [ROW_W-1:0] rst_row(input logic [RB-1:0] r);
    rst_row = (r == '0) ? ROW0_RESET : '0;
  endfunction

  assign accept = in_ch.valid && in_ch.ready;

  always_comb begin
    lim_ext = LW'(limit_r);
    lim     = (lim_ext > LW'(BLOCKS)) ? LW'(BLOCKS) : lim_ext;
  end

  // slot scan check stage
  assign slot_rd_id  = slot_rd_r[EW-1:BW];
  assign slot_rd_blk = slot_rd_r[BW-1:0];
  assign hit_now   = chk_on_r && slot_vld_r[chk_idx_r] && (slot_rd_id == id_r);
  assign free_now  = chk_on_r && !slot_vld_r[chk_idx_r];
  assign scan_end  = chk_on_r && (chk_idx_r == SLOT_LAST);
  assign match_any = match_r || hit_now;
  assign free_any  = free_r || free_now;

  // block map row check
  assign del_row = RB'(match_blk_r >> ROW_BW);
  assign del_bit = ROW_BW'(match_blk_r);
  assign chk_row = (state_r == S_DMOD) ? del_row : bchk_row_r;
  assign row_eff = row_vld_r[chk_row] ? blk_rd_r : rst_row(chk_row);

  always_comb begin
    pick_bit = '0;
    pick_any = 1'b0;
    for (int b = 0; b < ROW_W; b++) begin
      avail[b] = !row_eff[b] && (CW'({bchk_row_r, ROW_BW'(b)}) < CW'(lim));
    end
    for (int b = ROW_W - 1; b >= 0; b--) begin
      if (avail[b]) begin
        pick_bit = ROW_BW'(b);
        pick_any = 1'b1;
      end
    end
  end

  assign bfree_now = bchk_on_r && pick_any;
  assign bscan_end = bchk_on_r && (bchk_row_r == ROW_LAST);

  // result of the finished item
  always_comb begin
    res_status = ST_NOT_FOUND;
    res_slot   = '0;
    res_blk    = '0;
    case (op_r)
      OP_CREATE: begin
        if (match_r) begin
          res_status = ST_EXISTS;
        end else if (!free_r) begin
          res_status = ST_NO_SLOT;
        end else if (!bfound_r) begin
          res_status = ST_NO_BLOCK;
        end else begin
          res_status = ST_OK;
          res_slot   = free_slot_r;
          res_blk    = bfound_blk_r;
        end
      end
      OP_DELETE, OP_LOOKUP: begin
        if (match_r) begin
          res_status = ST_OK;
          res_slot   = match_slot_r;
          res_blk    = match_blk_r;
        end
      end
      default: res_status = ST_NOT_FOUND;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_ch.opcode inside {OP_CREATE, OP_DELETE, OP_LOOKUP}) begin
            state_nxt = S_SCAN;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          if (op_r == OP_CREATE && !match_any && free_any) begin
            state_nxt = S_BSCAN;
          end else if (op_r == OP_DELETE && match_any) begin
            state_nxt = S_DREAD;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_BSCAN: begin
        if (bscan_end) begin
          state_nxt = (bfound_r || bfree_now) ? S_COMMIT : S_RESP;
        end
      end
      S_COMMIT: state_nxt = S_RESP;
      S_DREAD:  state_nxt = S_DMOD;
      S_DMOD:   state_nxt = S_RESP;
      S_RESP: begin
        if (load_out) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ch.ready = 1'b0;
    slot_we     = 1'b0;
    blk_we      = 1'b0;
    blk_waddr   = bfound_row_r;
    blk_wdata   = bfound_word_r | (ROW_W'(1) << bfound_bit_r);
    blk_raddr   = bis_r;
    load_out    = 1'b0;
    case (state_r)
      S_IDLE:   in_ch.ready = 1'b1;
      S_COMMIT: begin
        slot_we = 1'b1;
        blk_we  = 1'b1;
      end
      S_DREAD:  blk_raddr = del_row;
      S_DMOD: begin
        blk_we    = 1'b1;
        blk_waddr = del_row;
        blk_wdata = row_eff & ~(ROW_W'(1) << del_bit);
      end
      S_RESP:   load_out = !out_vld_r || out_ch.ready;
      default: ;
    endcase
  end

  assign cfg_ch.ready       = 1'b1;
  assign out_ch.valid       = out_vld_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.slot_index  = out_slot_r;
  assign out_ch.blk_num     = out_blk_r;

  // memories
  always_ff @(posedge clk) begin
    if (slot_we) begin
      slot_mem[free_slot_r] <= {id_r, bfound_blk_r};
    end
    slot_rd_r <= slot_mem[iss_r];
  end

  always_ff @(posedge clk) begin
    if (blk_we) begin
      blk_mem[blk_waddr] <= blk_wdata;
    end
    blk_rd_r <= blk_mem[blk_raddr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      limit_r    <= LIMIT_RESET;
      slot_vld_r <= '0;
      row_vld_r  <= '0;
      iss_on_r   <= 1'b0;
      chk_on_r   <= 1'b0;
      bis_on_r   <= 1'b0;
      bchk_on_r  <= 1'b0;
      out_vld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        limit_r <= cfg_ch.data;
      end
      if (state_nxt == S_SCAN && state_r == S_IDLE) begin
        iss_on_r <= 1'b1;
      end else if (state_r == S_SCAN && iss_on_r && iss_r == SLOT_LAST) begin
        iss_on_r <= 1'b0;
      end
      chk_on_r <= (state_r == S_SCAN) && iss_on_r;
      if (state_nxt == S_BSCAN && state_r == S_SCAN) begin
        bis_on_r <= 1'b1;
      end else if (state_r == S_BSCAN && bis_on_r && bis_r == ROW_LAST) begin
        bis_on_r <= 1'b0;
      end
      bchk_on_r <= (state_r == S_BSCAN) && bis_on_r;
      if (slot_we) begin
        slot_vld_r[free_slot_r] <= 1'b1;
      end
      if (state_r == S_DMOD) begin
        slot_vld_r[match_slot_r] <= 1'b0;
      end
      if (blk_we) begin
        row_vld_r[blk_waddr] <= 1'b1;
      end
      if (load_out) begin
        out_vld_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= op_t'(in_ch.opcode);
      id_r     <= ID_BITS'(in_ch.file_id);
      iss_r    <= '0;
      match_r  <= 1'b0;
      free_r   <= 1'b0;
      bfound_r <= 1'b0;
    end else if (state_r == S_SCAN && iss_on_r && iss_r != SLOT_LAST) begin
      iss_r <= iss_r + 1'b1;
    end
    chk_idx_r <= iss_r;
    if (hit_now && !match_r) begin
      match_r      <= 1'b1;
      match_slot_r <= chk_idx_r;
      match_blk_r  <= slot_rd_blk;
    end
    if (free_now && !free_r) begin
      free_r      <= 1'b1;
      free_slot_r <= chk_idx_r;
    end
    if (state_r == S_SCAN) begin
      bis_r <= '0;
    end else if (state_r == S_BSCAN && bis_on_r && bis_r != ROW_LAST) begin
      bis_r <= bis_r + 1'b1;
    end
    bchk_row_r <= bis_r;
    if (bfree_now && !bfound_r) begin
      bfound_r      <= 1'b1;
      bfound_blk_r  <= BW'({bchk_row_r, pick_bit});
      bfound_row_r  <= bchk_row_r;
      bfound_bit_r  <= pick_bit;
      bfound_word_r <= row_eff;
    end
    if (load_out) begin
      out_status_r <= res_status;
      out_slot_r   <= SLOT_IDX_W'(res_slot);
      out_blk_r    <= BLOCK_NUM_W'(res_blk);
    end
  end

  a_commit_ready: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_COMMIT |-> free_r && bfound_r && !match_r)
    else $error("commit without a free slot and block");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SCAN || state_r == S_RESP))
    else $error("accepted item did not start");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && out_status_r != ST_OK |-> out_slot_r == '0 && out_blk_r == '0)
    else $error("error result carries nonzero fields");

  a_del_valid: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DMOD |-> slot_vld_r[match_slot_r])
    else $error("delete of a free slot");

endmodule
